FILE: hdl/slip_steering_wheel_mixer_defines.svh
// Assertion macros shared by the wheel mixer checker.
`ifndef SLIP_STEERING_WHEEL_MIXER_DEFINES_SVH
`define SLIP_STEERING_WHEEL_MIXER_DEFINES_SVH

// Checked only while out of reset.
`define SSWM_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define SSWM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/sswm_pkg.sv
// Shared types and constants of the slip-steering wheel mixer.
package sswm_pkg;

    localparam int ATAN_ENTRIES = 24;

    // Gain-compensated CORDIC start value, Q2.30
    localparam logic signed [31:0] CORDIC_X0 = 32'sh26DD3B6A;

    // atan(2^-i), 2^32 units per turn
    localparam logic signed [31:0] ATAN_TBL [ATAN_ENTRIES] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81
    };

    // Phase scaling divides by 1080 = 8 * 135; the 135 part goes by reciprocal
    localparam int DIVISOR = 135;
    localparam int RECIP_W = 25;
    localparam logic [RECIP_W-1:0] DIV_RECIP = 25'd31814572; // floor(2^32 / 135)

    // Lane order inside a cell
    localparam int LANE_LEFT  = 0;
    localparam int LANE_RIGHT = 1;

    // One wheel's rotator state
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_lane;

    // Item data that rides along the cell chain
    typedef struct packed {
        logic signed [15:0] speed;
        logic               bad;
        logic [1:0]         flip;
    } t_side;

endpackage

FILE: hdl/slip_steering_wheel_mixer.sv
// Top level of the slip-steering wheel mixer: command in, two wheel speeds out.
// o_valid rises after an item has passed the front, cell and back registers.
// One item per cycle unless stalled; every stage is a register with its own valid bit.
// Stall from the output reaches back combinationally; any empty stage absorbs it.
// Reset (synchronous, active low) clears all valid bits; payload registers keep data.
// o_stall is high only when every stage is full and the output is stalled.
module slip_steering_wheel_mixer #(
    parameter int COS_STAGES      = 16,   // CORDIC cells, 8..24
    parameter int ANGLE_FRAC_BITS = 6     // heading fraction bits, 2..8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command channel
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_speed_magnitude,
    input  logic signed [15:0] i_heading_angle,
    // wheel speed channel
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_left_speed,
    output logic signed [15:0] o_right_speed,
    output logic               o_angle_out_of_range
);

    // Data flow:
    //   front (4 stages): pick the cosine segment per wheel (left uses the
    //     negated heading), form the argument exactly in 1/(3*2^F) degree,
    //     scale it to a 2^32-per-turn phase rounded half away from zero
    //     (divide by 1080*2^F done as a shift plus reciprocal /135 and a
    //     remainder table), then fold the back half-plane and remember the
    //     sign flip.
    //   cells (COS_STAGES): one rotation each, both wheels in parallel
    //     lanes, handing x/y/z to the next cell every cycle unless stalled.
    //   back (3 stages): round x to Q2.14 and clamp to +-1.0, apply the
    //     flip, multiply by speed, round and saturate to 16 bits.
    // Out-of-range headings zero the profile, so both speeds come out 0.

    sswm_pkg::t_lane [1:0] w_lane  [COS_STAGES+1];
    sswm_pkg::t_side       w_side  [COS_STAGES+1];
    logic [COS_STAGES:0]   w_vld;
    logic [COS_STAGES:0]   w_stall;

    sswm_front #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_speed_magnitude (i_speed_magnitude),
        .i_heading_angle   (i_heading_angle),
        .o_valid           (w_vld[0]),
        .i_stall           (w_stall[0]),
        .o_side            (w_side[0]),
        .o_lane            (w_lane[0])
    );

    // rotation chain: cell g applies atan(2^-g)
    for (genvar g = 0; g < COS_STAGES; g++) begin : g_cell
        sswm_cell #(
            .STAGE (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_vld[g]),
            .o_stall (w_stall[g]),
            .i_side  (w_side[g]),
            .i_lane  (w_lane[g]),
            .o_valid (w_vld[g+1]),
            .i_stall (w_stall[g+1]),
            .o_side  (w_side[g+1]),
            .o_lane  (w_lane[g+1])
        );
    end

    sswm_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (w_vld[COS_STAGES]),
        .o_stall              (w_stall[COS_STAGES]),
        .i_side               (w_side[COS_STAGES]),
        .i_lane               (w_lane[COS_STAGES]),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_left_speed         (o_left_speed),
        .o_right_speed        (o_right_speed),
        .o_angle_out_of_range (o_angle_out_of_range)
    );

endmodule

FILE: hdl/sswm_cell.sv
// One CORDIC rotation cell, both wheels side by side.
module sswm_cell #(
    parameter int STAGE = 0
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  sswm_pkg::t_side          i_side,
    input  sswm_pkg::t_lane [1:0]    i_lane,
    output logic                     o_valid,
    input  logic                     i_stall,
    output sswm_pkg::t_side          o_side,
    output sswm_pkg::t_lane [1:0]    o_lane
);

    localparam logic signed [31:0] ANG = sswm_pkg::ATAN_TBL[STAGE];

    logic                  r_vld;
    logic                  w_en;
    sswm_pkg::t_side       r_side;
    sswm_pkg::t_lane [1:0] r_lane;
    sswm_pkg::t_lane [1:0] n_lane;
    logic signed [31:0]    w_dx [2];
    logic signed [31:0]    w_dy [2];

    assign w_en    = !r_vld || !i_stall;
    assign o_stall = !w_en;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_dx[k] = $signed(i_lane[k].y) >>> STAGE;
            w_dy[k] = $signed(i_lane[k].x) >>> STAGE;
            if (!i_lane[k].z[31]) begin
                n_lane[k].x = i_lane[k].x - w_dx[k];
                n_lane[k].y = i_lane[k].y + w_dy[k];
                n_lane[k].z = i_lane[k].z - ANG;
            end else begin
                n_lane[k].x = i_lane[k].x + w_dx[k];
                n_lane[k].y = i_lane[k].y - w_dy[k];
                n_lane[k].z = i_lane[k].z + ANG;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side <= i_side;
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_vld;
    assign o_side  = r_side;
    assign o_lane  = r_lane;

endmodule

FILE: hdl/sswm_front.sv
// Segment select, angle-to-phase scaling and half-plane fold.
module sswm_front #(
    parameter int ANGLE_FRAC_BITS = 6
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic signed [15:0]       i_speed_magnitude,
    input  logic signed [15:0]       i_heading_angle,
    output logic                     o_valid,
    input  logic                     i_stall,
    output sswm_pkg::t_side          o_side,
    output sswm_pkg::t_lane [1:0]    o_lane
);

    localparam int F  = ANGLE_FRAC_BITS;
    localparam int AW = 18;                      // wheel angle, holds -(-32768)
    localparam int TW = 20;                      // 3x argument before abs
    localparam int MW = F + 11;                  // |argument| <= 1080 * 2^F
    localparam int QW = F + 4;                   // |argument| / 135 <= 8 * 2^F
    localparam int KW = 29 - F;                  // fraction bits of the phase
    localparam int PW = MW + sswm_pkg::RECIP_W;

    localparam logic signed [AW-1:0] LIM_POS = AW'(180 << F);
    localparam logic signed [AW-1:0] LIM_NEG = -LIM_POS;
    localparam logic signed [AW-1:0] SEG_A   = -(AW'(135 << F));
    localparam logic signed [AW-1:0] SEG_C   = AW'(45 << F);
    localparam logic signed [TW-1:0] OFF90   = TW'(90 << F);

    logic [3:0] r_vld;
    logic [3:0] w_en;

    // fraction of the phase for each remainder modulo 135
    logic [KW-1:0] w_frac_tbl [sswm_pkg::DIVISOR];
    for (genvar g = 0; g < sswm_pkg::DIVISOR; g++) begin : g_frac
        localparam logic [63:0] FV =
            ((64'(g) << KW) + 64'd67) / 64'(sswm_pkg::DIVISOR);
        assign w_frac_tbl[g] = FV[KW-1:0];
    end

    always_comb begin
        w_en[3] = !r_vld[3] || !i_stall;
        w_en[2] = !r_vld[2] || w_en[3];
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
            if (w_en[3]) r_vld[3] <= r_vld[2];
        end
    end

    // ---- stage 1: segment, cosine argument in 1/(3*2^F) degree ----
    logic signed [AW-1:0] w_ang   [2];
    logic signed [TW-1:0] w_theta [2];
    logic signed [TW-1:0] w_abs   [2];
    logic [MW-1:0]        n1_mag  [2];
    logic [1:0]           n1_seg1;
    logic                 n1_bad;

    always_comb begin
        w_ang[sswm_pkg::LANE_LEFT]  = -AW'(i_heading_angle);
        w_ang[sswm_pkg::LANE_RIGHT] = AW'(i_heading_angle);
        for (int k = 0; k < 2; k++) begin
            n1_seg1[k] = 1'b0;
            priority if (w_ang[k] < SEG_A) begin
                w_theta[k] = (TW'(w_ang[k]) <<< 2) + (TW'(w_ang[k]) <<< 1);
                n1_seg1[k] = 1'b1;
            end else if (w_ang[k][AW-1]) begin
                w_theta[k] = TW'(w_ang[k]) <<< 1;
            end else if (w_ang[k] < SEG_C) begin
                w_theta[k] = (TW'(w_ang[k]) <<< 2) + (TW'(w_ang[k]) <<< 1);
            end else begin
                w_theta[k] = (TW'(w_ang[k]) + OFF90) <<< 1;
            end
            w_abs[k]  = w_theta[k][TW-1] ? -w_theta[k] : w_theta[k];
            n1_mag[k] = MW'(w_abs[k]);
        end
        // range is symmetric: one wheel decides for both
        n1_bad = (w_ang[sswm_pkg::LANE_RIGHT] < LIM_NEG) ||
                 (w_ang[sswm_pkg::LANE_RIGHT] > LIM_POS);
    end

    logic [MW-1:0]      r1_mag [2];
    logic [1:0]         r1_sgn;
    logic [1:0]         r1_seg1;
    logic               r1_bad;
    logic signed [15:0] r1_speed;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_mag   <= n1_mag;
            r1_sgn   <= {w_theta[1][TW-1], w_theta[0][TW-1]};
            r1_seg1  <= n1_seg1;
            r1_bad   <= n1_bad;
            r1_speed <= i_speed_magnitude;
        end
    end

    // ---- stage 2: reciprocal multiply for /135 ----
    logic [PW-1:0]      r2_prod [2];
    logic [MW-1:0]      r2_mag  [2];
    logic [1:0]         r2_sgn;
    logic [1:0]         r2_seg1;
    logic               r2_bad;
    logic signed [15:0] r2_speed;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int k = 0; k < 2; k++) begin
                r2_prod[k] <= PW'(r1_mag[k]) * PW'(sswm_pkg::DIV_RECIP);
            end
            r2_mag   <= r1_mag;
            r2_sgn   <= r1_sgn;
            r2_seg1  <= r1_seg1;
            r2_bad   <= r1_bad;
            r2_speed <= r1_speed;
        end
    end

    // ---- stage 3: quotient correction, remainder ----
    logic [QW-1:0] w_q0   [2];
    logic [MW-1:0] w_q135 [2];
    logic [MW-1:0] w_rem  [2];
    logic [QW-1:0] n3_m1  [2];
    logic [7:0]    n3_r1  [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_q0[k]   = r2_prod[k][PW-1:32];
            w_q135[k] = MW'(w_q0[k]) * MW'(sswm_pkg::DIVISOR);
            w_rem[k]  = r2_mag[k] - w_q135[k];
            if (w_rem[k] >= MW'(sswm_pkg::DIVISOR)) begin
                n3_m1[k] = w_q0[k] + QW'(1);
                n3_r1[k] = 8'(w_rem[k] - MW'(sswm_pkg::DIVISOR));
            end else begin
                n3_m1[k] = w_q0[k];
                n3_r1[k] = 8'(w_rem[k]);
            end
        end
    end

    logic [QW-1:0]      r3_m1 [2];
    logic [7:0]         r3_r1 [2];
    logic [1:0]         r3_sgn;
    logic [1:0]         r3_seg1;
    logic               r3_bad;
    logic signed [15:0] r3_speed;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_m1    <= n3_m1;
            r3_r1    <= n3_r1;
            r3_sgn   <= r2_sgn;
            r3_seg1  <= r2_seg1;
            r3_bad   <= r2_bad;
            r3_speed <= r2_speed;
        end
    end

    // ---- stage 4: 32-bit phase, fold back half-plane ----
    logic [QW+KW-1:0]      w_qfull [2];
    logic [31:0]           w_p     [2];
    logic [31:0]           w_t     [2];
    logic [1:0]            w_fold;
    sswm_pkg::t_lane [1:0] n4_lane;
    sswm_pkg::t_side       n4_side;

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_qfull[k] = {r3_m1[k], w_frac_tbl[r3_r1[k]]};
            w_p[k]     = r3_sgn[k] ? -w_qfull[k][31:0] : w_qfull[k][31:0];
            w_t[k]     = w_p[k] + 32'h4000_0000;
            w_fold[k]  = w_t[k][31];
            n4_lane[k].x = sswm_pkg::CORDIC_X0;
            n4_lane[k].y = '0;
            n4_lane[k].z = w_fold[k] ? $signed(w_p[k] + 32'h8000_0000)
                                     : $signed(w_p[k]);
        end
        n4_side.speed = r3_speed;
        n4_side.bad   = r3_bad;
        n4_side.flip  = r3_seg1 ^ w_fold;
    end

    sswm_pkg::t_lane [1:0] r4_lane;
    sswm_pkg::t_side       r4_side;

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_lane <= n4_lane;
            r4_side <= n4_side;
        end
    end

    assign o_lane = r4_lane;
    assign o_side = r4_side;

endmodule

FILE: hdl/sswm_back.sv
// Cosine rounding, speed multiply, saturation and output register.
module sswm_back (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  sswm_pkg::t_side          i_side,
    input  sswm_pkg::t_lane [1:0]    i_lane,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic signed [15:0]       o_left_speed,
    output logic signed [15:0]       o_right_speed,
    output logic                     o_angle_out_of_range
);

    localparam logic signed [16:0] C_MAX = 17'sd16384;
    localparam logic signed [16:0] C_MIN = -17'sd16384;
    localparam logic signed [17:0] S_MAX = 18'sd32767;
    localparam logic signed [17:0] S_MIN = -18'sd32768;

    logic [2:0] r_vld;
    logic [2:0] w_en;

    always_comb begin
        w_en[2] = !r_vld[2] || !i_stall;
        w_en[1] = !r_vld[1] || w_en[2];
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_vld[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) r_vld[0] <= i_valid;
            if (w_en[1]) r_vld[1] <= r_vld[0];
            if (w_en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // ---- stage 1: Q2.30 -> Q2.14 profile ----
    logic signed [32:0] w_xr   [2];
    logic signed [16:0] w_c    [2];
    logic signed [15:0] w_cl   [2];
    logic signed [15:0] n1_prof [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_xr[k] = 33'(i_lane[k].x) + 33'sd32768;
            w_c[k]  = w_xr[k][32:16];
            priority if (w_c[k] > C_MAX) begin
                w_cl[k] = 16'(C_MAX);
            end else if (w_c[k] < C_MIN) begin
                w_cl[k] = 16'(C_MIN);
            end else begin
                w_cl[k] = 16'(w_c[k]);
            end
            if (i_side.bad) begin
                n1_prof[k] = '0;
            end else begin
                n1_prof[k] = i_side.flip[k] ? -w_cl[k] : w_cl[k];
            end
        end
    end

    logic signed [15:0] r1_prof [2];
    logic signed [15:0] r1_speed;
    logic               r1_bad;

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_prof  <= n1_prof;
            r1_speed <= i_side.speed;
            r1_bad   <= i_side.bad;
        end
    end

    // ---- stage 2: speed * profile, Q18.14 ----
    logic signed [31:0] r2_prod [2];
    logic               r2_bad;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int k = 0; k < 2; k++) begin
                r2_prod[k] <= 32'(r1_speed) * 32'(r1_prof[k]);
            end
            r2_bad <= r1_bad;
        end
    end

    // ---- stage 3: round to Q16.0, saturate ----
    logic signed [31:0] w_sum [2];
    logic signed [17:0] w_rnd [2];
    logic signed [15:0] n3_spd [2];

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_sum[k] = r2_prod[k] + 32'sd8192;
            w_rnd[k] = w_sum[k][31:14];
            priority if (w_rnd[k] > S_MAX) begin
                n3_spd[k] = 16'(S_MAX);
            end else if (w_rnd[k] < S_MIN) begin
                n3_spd[k] = 16'(S_MIN);
            end else begin
                n3_spd[k] = 16'(w_rnd[k]);
            end
        end
    end

    logic signed [15:0] r3_left;
    logic signed [15:0] r3_right;
    logic               r3_bad;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_left  <= n3_spd[sswm_pkg::LANE_LEFT];
            r3_right <= n3_spd[sswm_pkg::LANE_RIGHT];
            r3_bad   <= r2_bad;
        end
    end

    assign o_left_speed         = r3_left;
    assign o_right_speed        = r3_right;
    assign o_angle_out_of_range = r3_bad;

endmodule

FILE: hdl/sswm_chk.sv
// Port-level checker for the wheel mixer, bound to the top level.
`include "slip_steering_wheel_mixer_defines.svh"

module sswm_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [15:0] i_speed_magnitude,
    input logic signed [15:0] i_heading_angle,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [15:0] o_left_speed,
    input logic signed [15:0] o_right_speed,
    input logic               o_angle_out_of_range
);

    `SSWM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")

    `SSWM_ASSERT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_left_speed) && $stable(o_right_speed) && $stable(o_angle_out_of_range), "stalled item changed")

    `SSWM_ASSERT(a_bad_zero, i_clk, i_rst_n, o_valid && o_angle_out_of_range |-> o_left_speed == 16'sd0 && o_right_speed == 16'sd0, "out of range item with nonzero speed")

    `SSWM_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> o_valid && i_stall, "input stalled while output drains")

endmodule

bind slip_steering_wheel_mixer sswm_chk u_sswm_chk (.*);
